// ===== design/ncdc_pkg.sv =====
// Shared types, codes and helper functions of the nixie clock display controller.
// No dependencies; used by ncdc_fill and nixie_clock_display_controller.
`timescale 1ns / 1ps
`default_nettype none

package ncdc_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int FILL_DIGITS    = 4;

  // request kinds
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_REFRESH = 2'd1;
  localparam logic [1:0] REQ_SCAN    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_MODE_DIV = 2'd1;
  localparam logic [1:0] CFG_POINT    = 2'd2;

  // display modes
  localparam logic [2:0] MODE_MAIN     = 3'd0;
  localparam logic [2:0] MODE_SET_HR   = 3'd1;
  localparam logic [2:0] MODE_SET_MIN  = 3'd2;
  localparam logic [2:0] MODE_SET_SEC  = 3'd3;
  localparam logic [2:0] MODE_SET_MAIN = 3'd4;
  localparam logic [2:0] MODE_SET_SENS = 3'd5;
  localparam logic [2:0] MODE_SECONDS  = 3'd6;
  localparam logic [2:0] MODE_TEMP     = 3'd7;

  localparam logic [3:0] BLANK_CODE   = 4'd10;
  localparam logic [3:0] SETTING_MARK = 4'd8;

  localparam logic [3:0] DEBOUNCE_RST  = 4'd3;
  localparam logic [7:0] MODE_DIV_RST  = 8'd20;
  localparam logic [7:0] POINT_PER_RST = 8'd5;
  localparam logic [6:0] MAIN_DUR_RST  = 7'd30;
  localparam logic [6:0] SENS_DUR_RST  = 7'd5;
  localparam logic [6:0] DUR_LIMIT     = 7'd60;
  localparam logic [6:0] DUR_STEP      = 7'd5;
  localparam logic [4:0] HOURS_MAX     = 5'd23;
  localparam logic [5:0] MINUTES_MAX   = 6'd59;
  localparam logic [6:0] TEMP_MAX      = 7'd99;

  typedef struct packed {
    logic [1:0] req_type;
    logic       btn1_pressed;
    logic       btn2_pressed;
    logic [4:0] rtc_hours;
    logic [5:0] rtc_minutes;
    logic [5:0] rtc_seconds;
    logic [6:0] temp_whole;
    logic       temp_half;
  } in_item_t;

  typedef struct packed {
    logic [3:0] cathode_code;
    logic [3:0] anode_select;
    logic       decimal_point;
    logic       rtc_write;
    logic [4:0] set_hours;
    logic [5:0] set_minutes;
    logic [5:0] set_seconds;
    logic [2:0] mode_now;
  } out_item_t;

  // sources of the digit fill
  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] main_dur;
    logic [6:0] sens_dur;
    logic [6:0] temp_whole;
    logic       temp_half;
  } fill_src_t;

  typedef logic [FILL_DIGITS-1:0][3:0] digits_t;

  // v / 10 by reciprocal, exact for every 7-bit v (v < 128)
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [6:0] q10;
    q10 = 7'(div10(v)) * 7'd10;
    return 4'(v - q10);
  endfunction

  function automatic logic [3:0] cathode_of(input logic [3:0] code);
    logic [3:0] c;
    case (code)
      4'd0:    c = 4'd0;
      4'd1:    c = 4'd1;
      4'd2:    c = 4'd4;
      4'd3:    c = 4'd5;
      4'd4:    c = 4'd8;
      4'd5:    c = 4'd9;
      4'd6:    c = 4'd12;
      4'd7:    c = 4'd13;
      4'd8:    c = 4'd2;
      4'd9:    c = 4'd3;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/nixie_clock_display_controller.sv =====
// An accepted item's result is in the output register in the next cycle.
// Throughput: one item per cycle; a new item is taken while the output register
// is empty or its result is being taken in the same cycle.
// Reset (rst_ni low, asynchronous): mode main, no hold, counters clear, durations
// 30 and 5, digits and latched time zero, config registers 3, 20 and 5.
// Files: ncdc_pkg, ncdc_fill.
`timescale 1ns / 1ps
`default_nettype none

module nixie_clock_display_controller #(
  parameter int NUM_DIGITS = ncdc_pkg::NUM_DIGITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  ncdc_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output ncdc_pkg::out_item_t    out_data_o,
  input  wire                    cfg_we_i,
  input  wire  [1:0]             cfg_idx_i,
  input  wire  [7:0]             cfg_data_i
);

  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // configuration
  logic [3:0] debounce_q;
  logic [7:0] mode_div_q;
  logic [7:0] point_per_q;

  // block state
  logic [2:0] mode_q, mode_d;
  logic       hold_q, hold_d;
  logic [6:0] dwell_q, dwell_d;
  logic [7:0] tick_q, tick_d;
  logic [3:0] b1cnt_q, b1cnt_d;
  logic [3:0] b2cnt_q, b2cnt_d;
  logic [6:0] main_dur_q, main_dur_d;
  logic [6:0] sens_dur_q, sens_dur_d;
  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic       point_q, point_d;
  logic [7:0] rcnt_q, rcnt_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic [3:0] digit_q [NUM_DIGITS];

  // output register
  logic                 out_valid_q;
  ncdc_pkg::out_item_t  out_q, out_d;

  ncdc_pkg::fill_src_t  fill_src;
  ncdc_pkg::digits_t    fill_digits;

  logic       accept;
  logic       do_fill;
  logic [3:0] deb_lim;
  logic [7:0] div_lim;
  logic [7:0] per_lim;
  logic [3:0] code;
  logic       wr;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a zero limit behaves as one
  assign deb_lim = (debounce_q == 4'd0) ? 4'd1 : debounce_q;
  assign div_lim = (mode_div_q == 8'd0) ? 8'd1 : mode_div_q;
  assign per_lim = (point_per_q == 8'd0) ? 8'd1 : point_per_q;

  // fill works on the freshly latched time of a refresh
  assign fill_src = '{mode: mode_q, hours: in_data_i.rtc_hours,
                      minutes: in_data_i.rtc_minutes, seconds: in_data_i.rtc_seconds,
                      main_dur: main_dur_q, sens_dur: sens_dur_q,
                      temp_whole: in_data_i.temp_whole, temp_half: in_data_i.temp_half};

  ncdc_fill u_fill (
    .src_i    (fill_src),
    .digits_o (fill_digits)
  );

  always_comb begin
    mode_d     = mode_q;
    hold_d     = hold_q;
    dwell_d    = dwell_q;
    tick_d     = tick_q;
    b1cnt_d    = b1cnt_q;
    b2cnt_d    = b2cnt_q;
    main_dur_d = main_dur_q;
    sens_dur_d = sens_dur_q;
    hours_d    = hours_q;
    minutes_d  = minutes_q;
    seconds_d  = seconds_q;
    point_d    = point_q;
    rcnt_d     = rcnt_q;
    scan_d     = scan_q;
    do_fill    = 1'b0;
    wr         = 1'b0;
    code       = digit_q[scan_q];
    out_d      = '0;

    case (in_data_i.req_type)
      ncdc_pkg::REQ_TICK: begin
        // automatic time / temperature alternation on the divided tick
        if (tick_q == 8'd0) begin
          if (mode_d == ncdc_pkg::MODE_MAIN) begin
            if (dwell_d < main_dur_q) begin
              dwell_d = dwell_d + 7'd1;
            end else if (sens_dur_q != 7'd0) begin
              dwell_d = 7'd0;
              mode_d  = ncdc_pkg::MODE_TEMP;
            end
          end
          if (!hold_q && mode_d == ncdc_pkg::MODE_TEMP) begin
            if (dwell_d < sens_dur_q) begin
              dwell_d = dwell_d + 7'd1;
            end else if (main_dur_q != 7'd0) begin
              dwell_d = 7'd0;
              mode_d  = ncdc_pkg::MODE_MAIN;
            end
          end
        end
        tick_d = tick_q + 8'd1;
        if (tick_d >= div_lim) begin
          tick_d = 8'd0;
        end

        // mode button
        if (in_data_i.btn1_pressed) begin
          b1cnt_d = b1cnt_q + 4'd1;
          if (b1cnt_d == deb_lim) begin
            mode_d  = (mode_d < ncdc_pkg::MODE_SET_SENS) ? mode_d + 3'd1 : ncdc_pkg::MODE_MAIN;
            b1cnt_d = 4'd0;
          end
        end else begin
          b1cnt_d = 4'd0;
        end

        // action button, acts on the mode left by the mode button
        if (in_data_i.btn2_pressed) begin
          b2cnt_d = b2cnt_q + 4'd1;
          if (b2cnt_d == deb_lim) begin
            b2cnt_d = 4'd0;
            case (mode_d)
              ncdc_pkg::MODE_MAIN: begin
                mode_d = ncdc_pkg::MODE_TEMP;
                hold_d = 1'b1;
              end
              ncdc_pkg::MODE_SET_HR: begin
                hours_d = (hours_q < ncdc_pkg::HOURS_MAX) ? hours_q + 5'd1 : 5'd0;
                wr      = 1'b1;
              end
              ncdc_pkg::MODE_SET_MIN: begin
                minutes_d = (minutes_q < ncdc_pkg::MINUTES_MAX) ? minutes_q + 6'd1 : 6'd0;
                wr        = 1'b1;
              end
              ncdc_pkg::MODE_SET_SEC: begin
                seconds_d = 6'd0;
                wr        = 1'b1;
              end
              ncdc_pkg::MODE_SET_MAIN: begin
                main_dur_d = (main_dur_q < ncdc_pkg::DUR_LIMIT) ?
                             main_dur_q + ncdc_pkg::DUR_STEP : 7'd0;
              end
              ncdc_pkg::MODE_SET_SENS: begin
                sens_dur_d = (sens_dur_q < ncdc_pkg::DUR_LIMIT) ?
                             sens_dur_q + ncdc_pkg::DUR_STEP : 7'd0;
              end
              ncdc_pkg::MODE_TEMP: begin
                hold_d = 1'b0;
                mode_d = ncdc_pkg::MODE_SECONDS;
              end
              default: begin
                mode_d = ncdc_pkg::MODE_MAIN;
              end
            endcase
          end
        end else begin
          b2cnt_d = 4'd0;
        end
      end

      ncdc_pkg::REQ_REFRESH: begin
        hours_d   = in_data_i.rtc_hours;
        minutes_d = in_data_i.rtc_minutes;
        seconds_d = in_data_i.rtc_seconds;
        rcnt_d    = rcnt_q + 8'd1;
        if (rcnt_d >= per_lim) begin
          rcnt_d  = 8'd0;
          point_d = !point_q;
        end
        do_fill = 1'b1;
        // temperature view keeps the point lit
        if (mode_q == ncdc_pkg::MODE_TEMP) begin
          point_d = 1'b1;
        end
      end

      ncdc_pkg::REQ_SCAN: begin
        // blank codes and slots past the fourth light nothing
        if (code < ncdc_pkg::BLANK_CODE && 32'(scan_q) < ncdc_pkg::FILL_DIGITS) begin
          out_d.cathode_code = ncdc_pkg::cathode_of(code);
          out_d.anode_select = 4'(4'd1 << 32'(scan_q));
        end
        if (32'(scan_q) == 2 &&
            (mode_q == ncdc_pkg::MODE_MAIN || mode_q == ncdc_pkg::MODE_TEMP)) begin
          out_d.decimal_point = point_q;
        end
        if (32'(scan_q) + 1 >= NUM_DIGITS) begin
          scan_d = '0;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end

      default: begin
      end
    endcase

    out_d.rtc_write   = wr;
    out_d.set_hours   = hours_d;
    out_d.set_minutes = minutes_d;
    out_d.set_seconds = seconds_d;
    out_d.mode_now    = mode_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= ncdc_pkg::DEBOUNCE_RST;
      mode_div_q  <= ncdc_pkg::MODE_DIV_RST;
      point_per_q <= ncdc_pkg::POINT_PER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ncdc_pkg::CFG_DEBOUNCE: debounce_q  <= cfg_data_i[3:0];
        ncdc_pkg::CFG_MODE_DIV: mode_div_q  <= cfg_data_i;
        ncdc_pkg::CFG_POINT:    point_per_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ncdc_pkg::MODE_MAIN;
      hold_q     <= 1'b0;
      dwell_q    <= '0;
      tick_q     <= '0;
      b1cnt_q    <= '0;
      b2cnt_q    <= '0;
      main_dur_q <= ncdc_pkg::MAIN_DUR_RST;
      sens_dur_q <= ncdc_pkg::SENS_DUR_RST;
      hours_q    <= '0;
      minutes_q  <= '0;
      seconds_q  <= '0;
      point_q    <= 1'b0;
      rcnt_q     <= '0;
      scan_q     <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_q[i] <= '0;
      end
    end else if (accept) begin
      mode_q     <= mode_d;
      hold_q     <= hold_d;
      dwell_q    <= dwell_d;
      tick_q     <= tick_d;
      b1cnt_q    <= b1cnt_d;
      b2cnt_q    <= b2cnt_d;
      main_dur_q <= main_dur_d;
      sens_dur_q <= sens_dur_d;
      hours_q    <= hours_d;
      minutes_q  <= minutes_d;
      seconds_q  <= seconds_d;
      point_q    <= point_d;
      rcnt_q     <= rcnt_d;
      scan_q     <= scan_d;
      if (do_fill) begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (i < ncdc_pkg::FILL_DIGITS) begin
            digit_q[i] <= fill_digits[i];
          end
        end
      end
    end
  end

  // output register: one result per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // a clock write only comes from a time-setting mode
  a_write_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rtc_write |->
      (out_data_o.mode_now == ncdc_pkg::MODE_SET_HR ||
       out_data_o.mode_now == ncdc_pkg::MODE_SET_MIN ||
       out_data_o.mode_now == ncdc_pkg::MODE_SET_SEC))
    else $error("rtc write outside a time-setting mode");

  // point only in main or temperature view
  a_point_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.decimal_point |->
      (out_data_o.mode_now == ncdc_pkg::MODE_MAIN ||
       out_data_o.mode_now == ncdc_pkg::MODE_TEMP))
    else $error("decimal point outside main or temperature view");

  a_anode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_data_o.anode_select))
    else $error("more than one anode selected");

  // dwell can never run past 65; the largest duration is 60
  a_dwell_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> dwell_q <= 7'd65)
    else $error("dwell counter out of range");
`endif

endmodule

`default_nettype wire

// ===== design/ncdc_fill.sv =====
// Digit fill: maps display mode and latched values to four digit codes.
// Depends on ncdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncdc_fill (
  input  wire  ncdc_pkg::fill_src_t src_i,
  output ncdc_pkg::digits_t         digits_o
);

  logic [6:0] temp_c;
  logic [6:0] val;
  logic [3:0] t_tens;

  always_comb begin
    temp_c = (src_i.temp_whole > ncdc_pkg::TEMP_MAX) ? ncdc_pkg::TEMP_MAX : src_i.temp_whole;
    t_tens = ncdc_pkg::div10(temp_c);
    case (src_i.mode)
      ncdc_pkg::MODE_SET_HR:   val = 7'(src_i.hours);
      ncdc_pkg::MODE_SET_MIN:  val = 7'(src_i.minutes);
      ncdc_pkg::MODE_SET_SEC:  val = 7'(src_i.seconds);
      ncdc_pkg::MODE_SET_MAIN: val = src_i.main_dur;
      default:                 val = src_i.sens_dur;
    endcase

    case (src_i.mode)
      ncdc_pkg::MODE_MAIN: begin
        digits_o[0] = ncdc_pkg::div10(7'(src_i.hours));
        digits_o[1] = ncdc_pkg::mod10(7'(src_i.hours));
        digits_o[2] = ncdc_pkg::div10(7'(src_i.minutes));
        digits_o[3] = ncdc_pkg::mod10(7'(src_i.minutes));
      end
      ncdc_pkg::MODE_SECONDS: begin
        digits_o[0] = ncdc_pkg::BLANK_CODE;
        digits_o[1] = ncdc_pkg::BLANK_CODE;
        digits_o[2] = ncdc_pkg::div10(7'(src_i.seconds));
        digits_o[3] = ncdc_pkg::mod10(7'(src_i.seconds));
      end
      ncdc_pkg::MODE_TEMP: begin
        // leading zero blanked, half degree as 5
        digits_o[0] = (t_tens != 4'd0) ? t_tens : ncdc_pkg::BLANK_CODE;
        digits_o[1] = ncdc_pkg::mod10(temp_c);
        digits_o[2] = src_i.temp_half ? 4'd5 : 4'd0;
        digits_o[3] = ncdc_pkg::BLANK_CODE;
      end
      default: begin
        digits_o[0] = ncdc_pkg::SETTING_MARK;
        digits_o[1] = 4'(src_i.mode);
        digits_o[2] = ncdc_pkg::div10(val);
        digits_o[3] = ncdc_pkg::mod10(val);
      end
    endcase
  end

endmodule

`default_nettype wire
